// ----- rtl/iee_pkg.sv -----
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types, constants and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int MAX_CHARS_DEF = 255;
  localparam int MAX_TERMS_DEF = 128;
  localparam int FRAC_BITS     = 32;

  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DIV_ZERO_LIMIT =
    ((64'd1 << FRAC_BITS) - 64'd1) / 64'd10000000000;
  localparam logic [3:0]  MAX_FRAC_DIGITS = 4'd15;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] ERR_OK      = 4'd0;
  localparam logic [3:0] ERR_EMPTY   = 4'd1;
  localparam logic [3:0] ERR_CHAR    = 4'd2;
  localparam logic [3:0] ERR_OPSEQ   = 4'd3;
  localparam logic [3:0] ERR_NONUM   = 4'd4;
  localparam logic [3:0] ERR_COUNT   = 4'd5;
  localparam logic [3:0] ERR_NUMBER  = 4'd6;
  localparam logic [3:0] ERR_DIVZERO = 4'd7;
  localparam logic [3:0] ERR_LONG    = 4'd8;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_CONV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  typedef struct packed {
    logic done;
  } alu_stat_t;

  function automatic logic [63:0] pow_ten(input logic [3:0] fd);
    logic [63:0] p;
    case (fd)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/iee_alu.sv -----
// ----------------------------------------------------------------------------
// iee_alu
// Shared iterative unit: shift-add multiply, shift-subtract divide and
// decimal to fixed-point conversion over one 66-bit adder.
// ----------------------------------------------------------------------------
module iee_alu (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iee_pkg::alu_ctrl_t ctrl_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output iee_pkg::alu_stat_t stat_o,
  output logic [63:0]        res_o
);
  import iee_pkg::*;

  localparam int CNTW = $clog2(64 + FRAC_BITS + 1);
  localparam logic [63:0] MUL_RND = 64'd1 << (FRAC_BITS - 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_DIV  = 3'd2;
  localparam logic [2:0] A_RND  = 3'd3;
  localparam logic [2:0] A_INC  = 3'd4;
  localparam logic [2:0] A_FIN  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic [63:0]     hi_q, hi_d, lo_q, lo_d, opd_q, opd_d, q_q, q_d, res_q, res_d;
  logic            neg_q, neg_d, over_q, over_d, rnd_q, rnd_d, mul_q, mul_d;

  logic [65:0]  x_a, x_b, sum;
  logic         x_sub;
  logic         na, nb;
  logic [63:0]  ma, mb, mag;
  logic         over;
  logic [127:0] prod;

  // shared adder
  always_comb begin
    x_a   = {2'b00, hi_q};
    x_b   = '0;
    x_sub = 1'b0;
    case (state_q)
      A_MUL: begin
        x_b = lo_q[0] ? {2'b00, opd_q} : '0;
      end
      A_DIV: begin
        x_a   = {1'b0, hi_q, lo_q[63]};
        x_b   = {2'b00, opd_q};
        x_sub = 1'b1;
      end
      A_RND: begin
        x_a   = {1'b0, hi_q, 1'b0};
        x_b   = {2'b00, opd_q};
        x_sub = 1'b1;
      end
      A_INC: begin
        x_a = {2'b00, q_q};
        x_b = {65'd0, rnd_q};
      end
      default: ;
    endcase
    sum = x_a + (x_sub ? ~x_b : x_b) + {65'd0, x_sub};
  end

  always_comb begin
    na   = (ctrl_i.op != ALU_CONV) && a_i[63];
    nb   = (ctrl_i.op != ALU_CONV) && b_i[63];
    ma   = na ? (~a_i + 64'd1) : a_i;
    mb   = nb ? (~b_i + 64'd1) : b_i;
    prod = {hi_q, lo_q};
    if (mul_q) begin
      mag  = prod[FRAC_BITS+63:FRAC_BITS];
      over = |prod[127:FRAC_BITS+64];
    end else begin
      mag  = q_q;
      over = over_q;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    hi_d    = hi_q;
    lo_d    = lo_q;
    opd_d   = opd_q;
    q_d     = q_q;
    res_d   = res_q;
    neg_d   = neg_q;
    over_d  = over_q;
    rnd_d   = rnd_q;
    mul_d   = mul_q;
    case (state_q)
      A_IDLE: begin
        if (ctrl_i.start) begin
          neg_d  = na ^ nb;
          over_d = 1'b0;
          q_d    = '0;
          if (ctrl_i.op == ALU_MUL) begin
            mul_d   = 1'b1;
            hi_d    = MUL_RND;
            lo_d    = mb;
            opd_d   = ma;
            cnt_d   = CNTW'(64);
            state_d = A_MUL;
          end else begin
            mul_d   = 1'b0;
            hi_d    = '0;
            lo_d    = ma;
            opd_d   = mb;
            cnt_d   = CNTW'(64 + FRAC_BITS);
            state_d = A_DIV;
          end
        end
      end
      A_MUL: begin
        hi_d  = sum[64:1];
        lo_d  = {sum[0], lo_q[63:1]};
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) state_d = A_FIN;
      end
      A_DIV: begin
        lo_d   = {lo_q[62:0], 1'b0};
        over_d = over_q | q_q[63];
        if (!sum[65]) begin
          hi_d = sum[63:0];
          q_d  = {q_q[62:0], 1'b1};
        end else begin
          hi_d = x_a[63:0];
          q_d  = {q_q[62:0], 1'b0};
        end
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) state_d = A_RND;
      end
      A_RND: begin
        rnd_d   = !sum[65];
        state_d = A_INC;
      end
      A_INC: begin
        q_d     = sum[63:0];
        over_d  = over_q | sum[64];
        state_d = A_FIN;
      end
      A_FIN: begin
        if (neg_q) begin
          res_d = (over || mag >= NEG_MIN) ? NEG_MIN : (~mag + 64'd1);
        end else begin
          res_d = (over || mag > POS_MAX) ? POS_MAX : mag;
        end
        done_d  = 1'b1;
        state_d = A_IDLE;
      end
      default: state_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    opd_q  <= opd_d;
    q_q    <= q_d;
    res_q  <= res_d;
    neg_q  <= neg_d;
    over_q <= over_d;
    rnd_q  <= rnd_d;
    mul_q  <= mul_d;
  end

  assign stat_o.done = done_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/infix_expression_evaluator.sv -----
// Append beat: a beat that ends a number first runs the decimal conversion in the shared
// unit; the operator or space is then filed in a post state before input is ready again.
// Evaluate beat: checks and first load, then per operator an add or subtract for + and -,
// or a run of the shared iterative unit for * and /, then the result goes to the output.
// The input is not ready while a number is converted or an evaluation runs.
// Reset is asynchronous, active low; counts, flags and error clear, the stores do not.
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Character-stream infix evaluator with * / before + -, signed fixed point.
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
  parameter int MAX_CHARS = iee_pkg::MAX_CHARS_DEF,
  parameter int MAX_TERMS = iee_pkg::MAX_TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code
  input  logic        s_axis_tuser_i,   // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o    // value[63:0], error_code[67:64], zero pad
);
  import iee_pkg::*;

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int HW = $clog2(MAX_CHARS + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CONV  = 4'd1;
  localparam logic [3:0] ST_POST  = 4'd2;
  localparam logic [3:0] ST_CHECK = 4'd3;
  localparam logic [3:0] ST_LD0   = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_OPR   = 4'd6;
  localparam logic [3:0] ST_ALU   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [1:0] PEND_OP    = 2'd0;
  localparam logic [1:0] PEND_SPACE = 2'd1;
  localparam logic [1:0] PEND_EVAL  = 2'd2;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] num_cnt_q, num_cnt_d, op_cnt_q, op_cnt_d, idx_q, idx_d;
  logic [HW-1:0] char_cnt_q, char_cnt_d;
  logic [63:0]   mant_q, mant_d;
  logic [3:0]    fd_q, fd_d, ferr_q, ferr_d;
  logic          in_num_q, in_num_d, seen_q, seen_d, prev_op_q, prev_op_d;
  logic [1:0]    pend_kind_q, pend_kind_d, pend_code_q, pend_code_d;
  logic [63:0]   cur_q, cur_d, sum_q, sum_d, res_val_q, res_val_d;
  logic          sub_q, sub_d;
  logic [3:0]    res_err_q, res_err_d;
  logic          m_valid_q, m_valid_d;
  logic [63:0]   m_val_q, m_val_d;
  logic [3:0]    m_err_q, m_err_d;

  logic [63:0]   num_mem [MAX_TERMS];
  logic [1:0]    op_mem  [MAX_TERMS];
  logic [63:0]   num_rd_q;
  logic [1:0]    op_rd_q;
  logic [AW-1:0] num_raddr;
  logic [CW-1:0] idx_inc;
  logic          num_we, op_we;

  alu_ctrl_t   alu_ctrl;
  alu_stat_t   alu_stat;
  logic [63:0] alu_a, alu_b, alu_res;

  logic [7:0]  ch;
  logic        is_digit, is_op, is_space;
  logic [1:0]  ch_code;
  logic [3:0]  dig;
  logic [67:0] m10;
  logic [63:0] nmag;
  logic [3:0]  chk_err;

  function automatic logic [3:0] latch_err(input logic [3:0] cur, input logic [3:0] e);
    return (cur == ERR_OK) ? e : cur;
  endfunction

  function automatic logic [63:0] sat_addsub(input logic [63:0] a, input logic [63:0] b,
                                             input logic sub);
    logic [63:0] bb, s;
    bb = sub ? ~b : b;
    s  = a + bb + {63'd0, sub};
    if ((a[63] == bb[63]) && (s[63] != a[63])) return a[63] ? NEG_MIN : POS_MAX;
    return s;
  endfunction

  iee_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .stat_o (alu_stat),
    .res_o  (alu_res)
  );

  assign ch       = s_axis_tdata_i;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_op    = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) ||
                    (ch == CH_SLASH);
  assign is_space = (ch == CH_SPACE);
  assign ch_code  = (ch == CH_PLUS) ? OP_ADD : (ch == CH_MINUS) ? OP_SUB :
                    (ch == CH_STAR) ? OP_MUL : OP_DIV;
  assign dig      = 4'(ch - CH_ZERO);
  assign m10      = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + 68'(dig);
  assign nmag     = num_rd_q[63] ? (~num_rd_q + 64'd1) : num_rd_q;
  assign idx_inc  = idx_q + CW'(1);
  assign num_raddr = (state_q == ST_CHECK) ? '0 : idx_inc[AW-1:0];

  assign alu_a = (state_q == ST_IDLE) ? mant_q : cur_q;
  assign alu_b = (state_q == ST_IDLE) ? pow_ten(fd_q) : num_rd_q;

  always_comb begin
    if (char_cnt_q == '0) chk_err = ERR_EMPTY;
    else if (ferr_q != ERR_OK) chk_err = ferr_q;
    else if (num_cnt_q == '0) chk_err = ERR_NONUM;
    else if ({1'b0, num_cnt_q} != ({1'b0, op_cnt_q} + (CW+1)'(1))) chk_err = ERR_COUNT;
    else chk_err = ERR_OK;
  end

  always_comb begin
    state_d     = state_q;
    num_cnt_d   = num_cnt_q;
    op_cnt_d    = op_cnt_q;
    idx_d       = idx_q;
    char_cnt_d  = char_cnt_q;
    mant_d      = mant_q;
    fd_d        = fd_q;
    ferr_d      = ferr_q;
    in_num_d    = in_num_q;
    seen_d      = seen_q;
    prev_op_d   = prev_op_q;
    pend_kind_d = pend_kind_q;
    pend_code_d = pend_code_q;
    cur_d       = cur_q;
    sum_d       = sum_q;
    sub_d       = sub_q;
    res_val_d   = res_val_q;
    res_err_d   = res_err_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_val_d     = m_val_q;
    m_err_d     = m_err_q;
    num_we      = 1'b0;
    op_we       = 1'b0;
    alu_ctrl.start = 1'b0;
    alu_ctrl.op    = ALU_CONV;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (!s_axis_tuser_i) begin
            if (char_cnt_q >= HW'(MAX_CHARS)) begin
              ferr_d = latch_err(ferr_q, ERR_LONG);
            end else begin
              char_cnt_d = char_cnt_q + HW'(1);
              if (ferr_q == ERR_OK) begin
                if (is_digit) begin
                  in_num_d  = 1'b1;
                  prev_op_d = 1'b0;
                  if (!seen_q || fd_q < MAX_FRAC_DIGITS) begin
                    mant_d = (|m10[67:64]) ? '1 : m10[63:0];
                    if (seen_q) fd_d = fd_q + 4'd1;
                  end
                end else if (ch == CH_POINT) begin
                  prev_op_d = 1'b0;
                  if (!in_num_q || seen_q) ferr_d = ERR_NUMBER;
                  else seen_d = 1'b1;
                end else if (is_op || is_space) begin
                  pend_kind_d = is_op ? PEND_OP : PEND_SPACE;
                  pend_code_d = ch_code;
                  in_num_d    = 1'b0;
                  seen_d      = 1'b0;
                  mant_d      = '0;
                  fd_d        = '0;
                  state_d     = ST_POST;
                  if (in_num_q) begin
                    if (num_cnt_q < CW'(MAX_TERMS)) begin
                      alu_ctrl.start = 1'b1;
                      state_d        = ST_CONV;
                    end else begin
                      ferr_d = ERR_LONG;
                    end
                  end
                end else begin
                  ferr_d = ERR_CHAR;
                end
              end
            end
          end else begin
            pend_kind_d = PEND_EVAL;
            in_num_d    = 1'b0;
            seen_d      = 1'b0;
            mant_d      = '0;
            fd_d        = '0;
            state_d     = ST_CHECK;
            if (in_num_q && ferr_q == ERR_OK) begin
              if (num_cnt_q < CW'(MAX_TERMS)) begin
                alu_ctrl.start = 1'b1;
                state_d        = ST_CONV;
              end else begin
                ferr_d = ERR_LONG;
              end
            end
          end
        end
      end
      ST_CONV: begin
        if (alu_stat.done) begin
          num_we    = 1'b1;
          num_cnt_d = num_cnt_q + CW'(1);
          state_d   = (pend_kind_q == PEND_EVAL) ? ST_CHECK : ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_IDLE;
        case (pend_kind_q)
          PEND_OP: begin
            prev_op_d = 1'b1;
            if (prev_op_q) begin
              ferr_d = latch_err(ferr_q, ERR_OPSEQ);
            end else if (op_cnt_q < CW'(MAX_TERMS)) begin
              op_we    = 1'b1;
              op_cnt_d = op_cnt_q + CW'(1);
            end else begin
              ferr_d = latch_err(ferr_q, ERR_LONG);
            end
          end
          PEND_SPACE: prev_op_d = 1'b0;
          default: state_d = ST_CHECK;
        endcase
      end
      ST_CHECK: begin
        if (chk_err != ERR_OK) begin
          res_val_d = '0;
          res_err_d = chk_err;
          state_d   = ST_OUT;
        end else begin
          state_d = ST_LD0;
        end
      end
      ST_LD0: begin
        cur_d   = num_rd_q;
        sum_d   = '0;
        sub_d   = 1'b0;
        idx_d   = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = (idx_q == op_cnt_q) ? ST_FIN : ST_OPR;
      end
      ST_OPR: begin
        case (op_rd_q)
          OP_MUL: begin
            alu_ctrl.start = 1'b1;
            alu_ctrl.op    = ALU_MUL;
            state_d        = ST_ALU;
          end
          OP_DIV: begin
            if (nmag <= DIV_ZERO_LIMIT) begin
              res_val_d = '0;
              res_err_d = ERR_DIVZERO;
              state_d   = ST_OUT;
            end else begin
              alu_ctrl.start = 1'b1;
              alu_ctrl.op    = ALU_DIV;
              state_d        = ST_ALU;
            end
          end
          default: begin
            sum_d   = sat_addsub(sum_q, cur_q, sub_q);
            sub_d   = op_rd_q[0];
            cur_d   = num_rd_q;
            idx_d   = idx_inc;
            state_d = ST_RD;
          end
        endcase
      end
      ST_ALU: begin
        if (alu_stat.done) begin
          cur_d   = alu_res;
          idx_d   = idx_inc;
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        res_val_d = sat_addsub(sum_q, cur_q, sub_q);
        res_err_d = ERR_OK;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_val_d    = res_val_q;
          m_err_d    = res_err_q;
          num_cnt_d  = '0;
          op_cnt_d   = '0;
          char_cnt_d = '0;
          prev_op_d  = 1'b0;
          ferr_d     = ERR_OK;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (num_we) num_mem[num_cnt_q[AW-1:0]] <= alu_res;
    if (op_we) op_mem[op_cnt_q[AW-1:0]] <= pend_code_q;
    num_rd_q <= num_mem[num_raddr];
    op_rd_q  <= op_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_cnt_q   <= '0;
      op_cnt_q    <= '0;
      idx_q       <= '0;
      char_cnt_q  <= '0;
      mant_q      <= '0;
      fd_q        <= '0;
      ferr_q      <= ERR_OK;
      in_num_q    <= 1'b0;
      seen_q      <= 1'b0;
      prev_op_q   <= 1'b0;
      pend_kind_q <= PEND_SPACE;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_cnt_q   <= num_cnt_d;
      op_cnt_q    <= op_cnt_d;
      idx_q       <= idx_d;
      char_cnt_q  <= char_cnt_d;
      mant_q      <= mant_d;
      fd_q        <= fd_d;
      ferr_q      <= ferr_d;
      in_num_q    <= in_num_d;
      seen_q      <= seen_d;
      prev_op_q   <= prev_op_d;
      pend_kind_q <= pend_kind_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_code_q <= pend_code_d;
    cur_q       <= cur_d;
    sum_q       <= sum_d;
    sub_q       <= sub_d;
    res_val_q   <= res_val_d;
    res_err_q   <= res_err_d;
    m_val_q     <= m_val_d;
    m_err_q     <= m_err_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'b0000, m_err_q, m_val_q};

endmodule

// ----- rtl/iee_checker.sv -----
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks of the infix expression evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module iee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tvalid_i,
  input logic        s_tready_i,
  input logic        s_tuser_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [71:0] m_tdata_i
);
  import iee_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result beat dropped before taken");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[67:64] <= ERR_LONG))
    else $error("error code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (m_tdata_i[67:64] != ERR_OK) |-> (m_tdata_i[63:0] == 64'd0))
    else $error("nonzero value with error");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[71:68] == 4'd0))
    else $error("pad bits not zero");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i && s_tuser_i |=> !s_tready_i)
    else $error("input ready right after evaluate beat");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .s_tuser_i  (s_axis_tuser_i),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
